### rtl/core/gb_pkg.sv
// Shared types and constants of the streaming 3x3 blur.
package gb_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;

    localparam int PIX_W       = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int WIDTH_W     = COL_W + 1;
    localparam int HEIGHT_W    = 13;
    localparam int WIDTH_FLD_W = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam int                  DIM_MIN      = 3;

    // Weights in thousandths
    localparam int W_CROSS = 84;
    localparam int W_DIAG  = 63;

    // floor(x/1000) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2**16
    localparam int RECIP       = 67109;
    localparam int RECIP_SHIFT = 26;

    localparam int BLUR_MAX    = 170;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } gb_reg_idx_t;

    typedef struct packed {
        logic                we;
        gb_reg_idx_t         index;
        logic [CFG_W-1:0]    data;
    } gb_cfg_t;

    // Neighborhood sums of one interior pixel plus its position
    typedef struct packed {
        logic [PIX_W+1:0]    s_vert;
        logic [PIX_W:0]      s_horz;
        logic [PIX_W:0]      s_lo;
        logic [PIX_W:0]      s_hi;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic                last;
    } gb_job_t;

endpackage

### rtl/core/gb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/gb_front.sv
// Front end: raster counters, line buffers, 3x3 window and interior classification.
module gb_front
    import gb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  gb_cfg_t          cfg,
    input  logic             accept,
    input  logic [PIX_W-1:0] pixel,
    output logic [1:0]       inflight,
    output logic             job_valid,
    output gb_job_t          job
);

    localparam int WIN_TAPS = 6;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic                s1_valid_reg;
    logic                s1_inner_reg;
    logic                s1_last_reg;
    logic [PIX_W-1:0]    s1_px_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;

    logic [PIX_W-1:0]    win_reg [WIN_TAPS];
    logic                job_valid_reg;
    gb_job_t             job_reg, job_next;

    logic [PIX_W-1:0]    mid_rdata;
    logic [PIX_W-1:0]    top_rdata;
    logic                col_wrap, row_wrap, inner, last_hit;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [CFG_W-1:0] d);
        logic [WIDTH_FLD_W-1:0] v;
        v = d[WIDTH_FLD_W-1:0];
        if (v < WIDTH_FLD_W'(DIM_MIN))
            return WIDTH_W'(DIM_MIN);
        else if (v > WIDTH_FLD_W'(MAX_WIDTH))
            return WIDTH_W'(MAX_WIDTH);
        else
            return WIDTH_W'(v);
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_W-1:0] d);
        logic [HEIGHT_W-1:0] v;
        v = d[HEIGHT_W-1:0];
        if (v < HEIGHT_W'(DIM_MIN))
            return HEIGHT_W'(DIM_MIN);
        else if (v > HEIGHT_W'(MAX_HEIGHT))
            return HEIGHT_W'(MAX_HEIGHT);
        else
            return v;
    endfunction

    // Row above the current one
    gb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .raddr (col_reg),
        .rdata (mid_rdata)
    );

    // Row two above the current one
    gb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_top_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_rdata),
        .raddr (col_reg),
        .rdata (top_rdata)
    );

    always_comb
    begin
        col_wrap = (WIDTH_W'(col_reg) + WIDTH_W'(1)) >= width_reg;
        row_wrap = (HEIGHT_W'(row_reg) + HEIGHT_W'(1)) >= height_reg;
        inner    = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        last_hit = (HEIGHT_W'(row_reg) == height_reg - HEIGHT_W'(1))
                && (WIDTH_W'(col_reg) == width_reg - WIDTH_W'(1));
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // Window taps: 0..2 two columns back, 3..5 one column back (top, mid, new row)
    always_comb
    begin
        job_next.s_vert = (PIX_W+2)'(win_reg[4]) + (PIX_W+2)'(win_reg[3])
                        + (PIX_W+2)'(win_reg[5]);
        job_next.s_horz = (PIX_W+1)'(win_reg[1]) + (PIX_W+1)'(mid_rdata);
        job_next.s_lo   = (PIX_W+1)'(s1_px_reg) + (PIX_W+1)'(win_reg[2]);
        job_next.s_hi   = (PIX_W+1)'(top_rdata) + (PIX_W+1)'(win_reg[0]);
        job_next.row    = s1_row_reg - ROW_W'(1);
        job_next.col    = s1_col_reg - COL_W'(1);
        job_next.last   = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            job_valid_reg <= 1'b0;
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.we)
            begin
                case (cfg.index)
                    REG_IMAGE_WIDTH:  width_reg  <= clamp_width(cfg.data);
                    REG_IMAGE_HEIGHT: height_reg <= clamp_height(cfg.data);
                    default:          ;
                endcase
                // restart the frame
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            s1_valid_reg  <= accept;
            job_valid_reg <= s1_valid_reg && s1_inner_reg;

            if (s1_valid_reg)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_rdata;
                win_reg[4] <= mid_rdata;
                win_reg[5] <= s1_px_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_inner_reg <= inner;
            s1_last_reg  <= last_hit;
        end
        if (s1_valid_reg)
        begin
            job_reg <= job_next;
        end
    end

    assign inflight  = 2'(s1_valid_reg) + 2'(job_valid_reg);
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

### rtl/core/gb_queue.sv
// Short queue of pending blur jobs between front and back end.
module gb_queue
    import gb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gb_job_t           push_job,
    input  logic              pop,
    output logic              avail,
    output gb_job_t           head,
    output logic [QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    gb_job_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign avail = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

### rtl/core/gb_back.sv
// Back end: weight, divide by 1000 through a reciprocal, sum, and hold the result beat.
module gb_back
    import gb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             avail,
    input  gb_job_t          job,
    output logic             take,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [PIX_W-1:0] blurred,
    output logic [ROW_W-1:0] out_row,
    output logic [COL_W-1:0] out_col,
    output logic             frame_last
);

    localparam int PROD_W = 16;
    localparam int MUL_W  = PROD_W + 17;
    localparam int QUO_W  = MUL_W - RECIP_SHIFT;
    localparam int ACC_W  = QUO_W + 2;

    typedef struct packed {
        logic [PROD_W-1:0] p_vert;
        logic [PROD_W-1:0] p_horz;
        logic [PROD_W-1:0] p_lo;
        logic [PROD_W-1:0] p_hi;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } gb_prod_t;

    typedef struct packed {
        logic [QUO_W-1:0]  q_vert;
        logic [QUO_W-1:0]  q_horz;
        logic [QUO_W-1:0]  q_lo;
        logic [QUO_W-1:0]  q_hi;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } gb_quo_t;

    logic             advance;
    logic             b1_valid_reg, b2_valid_reg, out_valid_reg;
    gb_prod_t         b1_reg, b1_next;
    gb_quo_t          b2_reg, b2_next;
    logic [ACC_W-1:0] acc;
    logic [PIX_W-1:0] blurred_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             last_reg;

    function automatic logic [QUO_W-1:0] div1000(input logic [PROD_W-1:0] p);
        logic [MUL_W-1:0] m;
        m = MUL_W'(p) * MUL_W'(RECIP);
        return m[MUL_W-1:RECIP_SHIFT];
    endfunction

    // The whole back end moves together; stall it while the result beat waits
    assign advance = !out_valid_reg || result_ready;
    assign take    = avail && advance;

    always_comb
    begin
        b1_next.p_vert = PROD_W'(job.s_vert) * PROD_W'(W_CROSS);
        b1_next.p_horz = PROD_W'(job.s_horz) * PROD_W'(W_CROSS);
        b1_next.p_lo   = PROD_W'(job.s_lo) * PROD_W'(W_DIAG);
        b1_next.p_hi   = PROD_W'(job.s_hi) * PROD_W'(W_DIAG);
        b1_next.row    = job.row;
        b1_next.col    = job.col;
        b1_next.last   = job.last;

        b2_next.q_vert = div1000(b1_reg.p_vert);
        b2_next.q_horz = div1000(b1_reg.p_horz);
        b2_next.q_lo   = div1000(b1_reg.p_lo);
        b2_next.q_hi   = div1000(b1_reg.p_hi);
        b2_next.row    = b1_reg.row;
        b2_next.col    = b1_reg.col;
        b2_next.last   = b1_reg.last;

        acc = ACC_W'(b2_reg.q_vert) + ACC_W'(b2_reg.q_horz)
            + ACC_W'(b2_reg.q_lo) + ACC_W'(b2_reg.q_hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg  <= take;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_reg      <= b1_next;
            b2_reg      <= b2_next;
            blurred_reg <= acc[PIX_W-1:0];
            row_reg     <= b2_reg.row;
            col_reg     <= b2_reg.col;
            last_reg    <= b2_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign blurred      = blurred_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign frame_last   = last_reg;

endmodule

### rtl/core/gaussian_blur_3x3_stream.sv
// Top level of the streaming 3x3 blur: ports, flow control and checks.
//
// Pixels enter in raster order on pixel_valid/pixel_ready, one beat per pixel.
// Each interior pixel (not in the first or last row or column) yields one
// result beat on result_valid/result_ready carrying blurred, out_row, out_col
// and frame_last; border pixels yield nothing. A result leaves one row and
// one column after its center pixel, once its bottom-right neighbor arrives.
// Throughput is one pixel per clock while pixel_ready is high; each pixel does
// one read and one write on each of the two line-buffer RAMs. A result beat
// passes the s1, job, queue, b1, b2 and out registers after its last pixel.
// Configuration: cfg_we with cfg_index 0 writes image_width, 1 writes
// image_height (width from cfg_data[11:0]; values clamped to the legal range);
// a write restarts the frame. Write only while no beat is in flight.
// Reset clears the counters, the window and all valid flags and loads a
// 640 x 480 frame size; line buffers need no clearing.
// When the receiver stalls, up to four jobs wait in a queue between the window
// logic and the arithmetic; pixel_ready drops once the queue plus the jobs
// still in the window pipeline would fill it.
module gaussian_blur_3x3_stream
    import gb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  logic [PIX_W-1:0]     pixel,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [PIX_W-1:0]     blurred,
    output logic [ROW_W-1:0]     out_row,
    output logic [COL_W-1:0]     out_col,
    output logic                 frame_last
);

    gb_cfg_t           cfg;
    logic              accept;
    logic [1:0]        inflight;
    logic              job_valid;
    gb_job_t           job;
    logic              q_avail;
    gb_job_t           q_head;
    logic [QCNT_W-1:0] q_count;
    logic              q_pop;
    logic [QCNT_W-1:0] pending;

    assign cfg.we    = cfg_we;
    assign cfg.index = gb_reg_idx_t'(cfg_index);
    assign cfg.data  = cfg_data;

    // Reserve a queue slot for every pixel still in the window pipeline
    assign pending     = q_count + QCNT_W'(inflight);
    assign pixel_ready = pending < QCNT_W'(QUEUE_DEPTH);
    assign accept      = pixel_valid && pixel_ready;

    gb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .pixel     (pixel),
        .inflight  (inflight),
        .job_valid (job_valid),
        .job       (job)
    );

    gb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head),
        .count    (q_count)
    );

    gb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .avail        (q_avail),
        .job          (q_head),
        .take         (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .blurred      (blurred),
        .out_row      (out_row),
        .out_col      (out_col),
        .frame_last   (frame_last)
    );

`ifndef SYNTHESIS
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue reservation exceeded its depth");

    a_blur_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> blurred <= PIX_W'(BLUR_MAX))
        else $error("blurred value above its bound");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (out_row != '0) && (out_col != '0))
        else $error("result beat for a border pixel");

    a_no_idle_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == '0) && (inflight == 2'd0) |-> pixel_ready)
        else $error("input stalled with nothing pending");
`endif

endmodule
